// ===== sv/lpfu_pkg.sv =====
// Shared types, register codes and widths for the LED pixel format unpacker.
package lpfu_pkg;

  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 10;
  localparam int IDX_W   = 11;
  localparam int SEG_W   = 7;
  localparam int SPAN_W  = 18;
  localparam int LED_W   = 17;
  localparam int FMT_W   = 3;
  localparam int KIND_W  = 2;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam int MAX_LEDS_DEF    = 1024;
  localparam int MAX_SEGMENT_DEF = 64;
  localparam int QUEUE_DEPTH     = 4;

  typedef logic [FMT_W-1:0]  fmt_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [2:0]        reg_idx_t;

  localparam fmt_t FMT_RGB  = 3'd0;
  localparam fmt_t FMT_BGR  = 3'd1;
  localparam fmt_t FMT_GRB  = 3'd2;
  localparam fmt_t FMT_RGBA = 3'd3;
  localparam fmt_t FMT_RGBW = 3'd4;

  localparam kind_t KIND_NONE   = 2'd0;
  localparam kind_t KIND_DIMMER = 2'd1;
  localparam kind_t KIND_WHITE  = 2'd2;

  localparam reg_idx_t REG_FORMAT  = 3'd0;
  localparam reg_idx_t REG_START   = 3'd1;
  localparam reg_idx_t REG_COUNT   = 3'd2;
  localparam reg_idx_t REG_SEGMENT = 3'd3;
  localparam reg_idx_t REG_TOTAL   = 3'd4;
  localparam reg_idx_t REG_KIND    = 3'd5;
  localparam reg_idx_t REG_DEFAULT = 3'd6;

  // Effective configuration as seen by the datapath.
  typedef struct packed {
    fmt_t              format;
    logic [IDX_W-1:0]  start_index;
    logic [IDX_W-1:0]  count;
    logic [SEG_W-1:0]  seg;
    logic [IDX_W-1:0]  total;
    kind_t             kind;
    logic [BYTE_W-1:0] dflt;
  } cfg_t;

  // One classified pixel waiting for its segment writes.
  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] extra;
    logic [IDX_W-1:0]  base;
    logic [SPAN_W-1:0] span;
  } pix_t;

endpackage

// ===== sv/lpfu_regs.sv =====
// Configuration register file with APB-style access and effective-value derivation.
module lpfu_regs
  import lpfu_pkg::*;
#(
  parameter int MAX_LEDS    = MAX_LEDS_DEF,
  parameter int MAX_SEGMENT = MAX_SEGMENT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  localparam logic [LED_W-1:0] LED_LIMIT = LED_W'(MAX_LEDS);
  localparam logic [SEG_W-1:0] SEG_LIMIT = SEG_W'(MAX_SEGMENT);

  fmt_t              pixel_format;
  logic [IDX_W-1:0]  start_index;
  logic [IDX_W-1:0]  pixel_count;
  logic [SEG_W-1:0]  segment_length;
  logic [IDX_W-1:0]  total_leds;
  kind_t             param_kind;
  logic [BYTE_W-1:0] param_default;

  reg_idx_t         reg_sel;
  logic             wr_en;
  logic [IDX_W-1:0] total_eff;
  logic [SEG_W-1:0] seg_nz;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format   <= FMT_RGB;
      start_index    <= '0;
      pixel_count    <= '0;
      segment_length <= SEG_W'(1);
      total_leds     <= IDX_W'(1024);
      param_kind     <= KIND_NONE;
      param_default  <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FORMAT:  pixel_format   <= pwdata[FMT_W-1:0];
        REG_START:   start_index    <= pwdata[IDX_W-1:0];
        REG_COUNT:   pixel_count    <= pwdata[IDX_W-1:0];
        REG_SEGMENT: segment_length <= pwdata[SEG_W-1:0];
        REG_TOTAL:   total_leds     <= pwdata[IDX_W-1:0];
        REG_KIND:    param_kind     <= pwdata[KIND_W-1:0];
        REG_DEFAULT: param_default  <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FORMAT:  prdata = PDATA_W'(pixel_format);
      REG_START:   prdata = PDATA_W'(start_index);
      REG_COUNT:   prdata = PDATA_W'(pixel_count);
      REG_SEGMENT: prdata = PDATA_W'(segment_length);
      REG_TOTAL:   prdata = PDATA_W'(total_leds);
      REG_KIND:    prdata = PDATA_W'(param_kind);
      REG_DEFAULT: prdata = PDATA_W'(param_default);
      default:     prdata = '0;
    endcase
  end

  // Clip the LED total and segment length to the build limits.
  assign total_eff = (LED_W'(total_leds) > LED_LIMIT) ? LED_LIMIT[IDX_W-1:0] : total_leds;
  assign seg_nz    = (segment_length == '0) ? SEG_W'(1) : segment_length;

  always_comb begin
    cfg.format      = pixel_format;
    cfg.start_index = start_index;
    cfg.count       = (pixel_count == '0) ? total_eff : pixel_count;
    cfg.seg         = (seg_nz > SEG_LIMIT) ? SEG_LIMIT : seg_nz;
    cfg.total       = total_eff;
    cfg.kind        = param_kind;
    cfg.dflt        = param_default;
  end

endmodule

// ===== sv/lpfu_front.sv =====
// Front end: gathers packet bytes into pixels and classifies them for the queue.
module lpfu_front
  import lpfu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  output logic              byte_stall,
  input  cfg_t              cfg,
  input  logic              queue_full,
  output logic              push,
  output pix_t              entry
);

  logic [1:0]        byte_phase;
  logic [BYTE_W-1:0] held [3];
  logic [IDX_W-1:0]  pixel_number;
  logic [IDX_W-1:0]  base_address;

  logic              accept;
  logic              four;
  logic              complete;
  logic              use_byte;
  logic              fmt_ok;
  logic              n_ok;
  logic [BYTE_W-1:0] b2;

  assign byte_stall = queue_full;
  assign accept     = byte_valid && !queue_full;

  assign four     = (cfg.format == FMT_RGBA) || (cfg.format == FMT_RGBW);
  assign complete = four ? (byte_phase == 2'd3) : (byte_phase >= 2'd2);
  assign b2       = four ? held[2] : data_byte;
  assign use_byte = ((cfg.format == FMT_RGBA) && (cfg.kind == KIND_DIMMER)) ||
                    ((cfg.format == FMT_RGBW) && (cfg.kind == KIND_WHITE));
  assign fmt_ok   = cfg.format <= FMT_RGBW;
  assign n_ok     = pixel_number < cfg.count;
  assign push     = accept && complete && fmt_ok && n_ok;

  always_comb begin
    entry.red   = '0;
    entry.green = '0;
    entry.blue  = '0;
    case (cfg.format) inside
      FMT_BGR: begin
        entry.blue  = held[0];
        entry.green = held[1];
        entry.red   = b2;
      end
      FMT_GRB: begin
        entry.green = held[0];
        entry.red   = held[1];
        entry.blue  = b2;
      end
      FMT_RGB, FMT_RGBA, FMT_RGBW: begin
        entry.red   = held[0];
        entry.green = held[1];
        entry.blue  = b2;
      end
      default: ;
    endcase
    entry.extra = use_byte ? data_byte : cfg.dflt;
    entry.base  = base_address;
    // Offset of this pixel's first LED from the packet base.
    entry.span  = SPAN_W'(pixel_number) * SPAN_W'(cfg.seg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase   <= '0;
      pixel_number <= '0;
      base_address <= '0;
    end else if (accept) begin
      if ((byte_phase == '0) && (pixel_number == '0)) begin
        base_address <= cfg.start_index;
      end
      if (last_byte) begin
        byte_phase   <= '0;
        pixel_number <= '0;
      end else if (complete) begin
        byte_phase <= '0;
        if (pixel_number != '1) begin
          pixel_number <= pixel_number + IDX_W'(1);
        end
      end else begin
        byte_phase <= byte_phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !complete) begin
      held[byte_phase] <= data_byte;
    end
  end

endmodule

// ===== sv/lpfu_queue.sv =====
// Short pixel queue between the front end and the segment writer.
module lpfu_queue
  import lpfu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pix_t wr_entry,
  input  logic pop,
  output pix_t rd_entry,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  pix_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full     = fill == FULL_CNT;
  assign empty    = fill == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

// ===== sv/lpfu_back.sv =====
// Back end: checks each queued pixel against the LED total and writes its segment.
module lpfu_back
  import lpfu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  pix_t              entry,
  input  logic              empty,
  output logic              pop,
  output logic              led_valid,
  input  logic              led_stall,
  output logic [ADDR_W-1:0] led_address,
  output logic [BYTE_W-1:0] red,
  output logic [BYTE_W-1:0] green,
  output logic [BYTE_W-1:0] blue,
  output logic [BYTE_W-1:0] extra_channel,
  output logic              last_copy
);

  logic              active;
  pix_t              cur;
  logic [ADDR_W-1:0] addr;
  logic [SEG_W-1:0]  copy;

  logic              slot_free;
  logic              emit;
  logic              final_copy;
  logic [SPAN_W-1:0] first_led;
  logic [SPAN_W-1:0] end_led;
  logic              fits;

  assign slot_free  = !led_valid || !led_stall;
  assign emit       = active && slot_free;
  assign final_copy = copy == (cfg.seg - SEG_W'(1));
  assign pop        = !empty && (!active || (emit && final_copy));

  assign first_led = SPAN_W'(entry.base) + entry.span;
  assign end_led   = first_led + SPAN_W'(cfg.seg);
  assign fits      = end_led <= SPAN_W'(cfg.total);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      led_valid <= 1'b0;
    end else begin
      if (emit) begin
        led_valid <= 1'b1;
      end else if (!led_stall) begin
        led_valid <= 1'b0;
      end
      if (pop) begin
        active <= fits;
      end else if (emit && final_copy) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      led_address   <= addr;
      red           <= cur.red;
      green         <= cur.green;
      blue          <= cur.blue;
      extra_channel <= cur.extra;
      last_copy     <= final_copy;
    end
    if (pop) begin
      cur  <= entry;
      addr <= first_led[ADDR_W-1:0];
      copy <= '0;
    end else if (emit) begin
      addr <= addr + ADDR_W'(1);
      copy <= copy + SEG_W'(1);
    end
  end

endmodule

// ===== sv/led_pixel_format_unpacker.sv =====
// Top level of the LED pixel format unpacker.
// Takes a pixel packet one byte per transfer and gathers 3 bytes (rgb, bgr,
// grb) or 4 bytes (rgba, rgbw) into a pixel; pixel n of the packet is written
// to segment_length consecutive LED addresses starting at
// start_index + n * segment_length, one write per cycle while not stalled, with
// last_copy marking the final write of each pixel. A pixel is written only
// while n is below pixel_count (0 means the LED total) and its whole segment
// ends at or below total_leds; otherwise its bytes are still consumed. The
// fourth byte drives extra_channel only for rgba with the dimmer kind or
// rgbw with the white kind, else param_default appears there. The byte after
// last_byte starts a new packet; a trailing partial pixel is dropped.
// Rate: one byte is accepted every cycle while the 4-entry pixel queue has
// room; the segment writer emits one LED write per cycle while led_stall is
// low, and a pixel that fails the range check is popped without any write.
// Input stall rises only when the queue is full, which happens
// when the byte stream outpaces the segment writes (segment_length above the
// bytes per pixel) or the output side stalls. Write configuration only while
// no transfer is in flight.
module led_pixel_format_unpacker
  import lpfu_pkg::*;
#(
  parameter int MAX_LEDS    = MAX_LEDS_DEF,
  parameter int MAX_SEGMENT = MAX_SEGMENT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // packet byte stream
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               last_byte,
  // LED write stream
  output logic               led_valid,
  input  logic               led_stall,
  output logic [ADDR_W-1:0]  led_address,
  output logic [BYTE_W-1:0]  red,
  output logic [BYTE_W-1:0]  green,
  output logic [BYTE_W-1:0]  blue,
  output logic [BYTE_W-1:0]  extra_channel,
  output logic               last_copy
);

  cfg_t cfg;
  pix_t push_entry;
  pix_t pop_entry;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;

  lpfu_regs #(
    .MAX_LEDS    (MAX_LEDS),
    .MAX_SEGMENT (MAX_SEGMENT)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Classify each completed pixel; drop those past the count or of an
  // unknown format before they reach the queue.
  lpfu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .byte_stall (byte_stall),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .entry      (push_entry)
  );

  // Decouple byte intake from segment replication.
  lpfu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (pop),
    .rd_entry (pop_entry),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  // Range-check against the LED total and emit the segment writes.
  lpfu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .entry         (pop_entry),
    .empty         (queue_empty),
    .pop           (pop),
    .led_valid     (led_valid),
    .led_stall     (led_stall),
    .led_address   (led_address),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .extra_channel (extra_channel),
    .last_copy     (last_copy)
  );

endmodule

// ===== sv/lpfu_checker.sv =====
// Port-level checker for the LED pixel format unpacker, bound to the top level.
module lpfu_checker
  import lpfu_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               pready,
  input logic               led_valid,
  input logic               led_stall,
  input logic [ADDR_W-1:0]  led_address,
  input logic [BYTE_W-1:0]  red,
  input logic [BYTE_W-1:0]  green,
  input logic [BYTE_W-1:0]  blue,
  input logic [BYTE_W-1:0]  extra_channel,
  input logic               last_copy
);

  // Reset empties the write stream.
  a_reset_idle: assert property (@(posedge clk) rst |=> !led_valid)
    else $error("led_valid high after reset");

  // A stalled write holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    led_valid && led_stall |=> led_valid && $stable(led_address) && $stable(red) &&
      $stable(green) && $stable(blue) && $stable(extra_channel) && $stable(last_copy))
    else $error("stalled LED write changed");

  // Back-to-back writes of one segment step the address and keep the colors.
  a_segment_step: assert property (@(posedge clk) disable iff (rst)
    (led_valid && !led_stall && !last_copy) ##1 (led_valid && !led_stall) |->
      led_address == ADDR_W'($past(led_address) + ADDR_W'(1)) &&
      red == $past(red) && green == $past(green) && blue == $past(blue) &&
      extra_channel == $past(extra_channel))
    else $error("segment write out of sequence");

  // The register port never inserts wait states.
  a_no_wait: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind led_pixel_format_unpacker lpfu_checker u_lpfu_checker (.*);
